/* hw/rtl/tcan_pkg.sv */
// Package for the triangle centroid, area and normal pipeline: widths, payload types, helpers.
package tcan_pkg;

    localparam int COORD_BITS = 24;
    localparam int TAG_W      = 20;

    // edge vectors and cross product terms
    localparam int D_W   = COORD_BITS + 1;
    localparam int PN_W  = 2 * D_W;
    localparam int N_W   = 2 * COORD_BITS + 1;
    localparam int NL_W  = (N_W + 1) / 2;
    localparam int NH_W  = N_W - NL_W;
    localparam int S_W   = 2 * N_W + 2;
    localparam int LEN_W = N_W + 1;

    // triple product terms
    localparam int PB_W      = 2 * COORD_BITS;
    localparam int BC_W      = 2 * COORD_BITS;
    localparam int BCL_W     = BC_W / 2;
    localparam int BCH_W     = BC_W - BCL_W;
    localparam int VP_W      = COORD_BITS + BC_W;
    localparam int T_W       = VP_W + 2;
    localparam int VOL_SHIFT = 17;
    localparam int VQ_W      = T_W - 1 - VOL_SHIFT;

    // divide by three, one byte per stage
    localparam int CHUNK_W = 8;
    localparam int VW_W    = ((VQ_W + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
    localparam int VCH     = VW_W / CHUNK_W;
    localparam int CS_W    = COORD_BITS + 2;
    localparam int CW_W    = ((CS_W + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
    localparam int CCH     = CW_W / CHUNK_W;

    localparam int FRAC_W = 31;
    localparam int NORM_W = 32;
    localparam int AREA_W = 48;
    localparam int VOL_W  = 60;

    localparam logic [63:0] VOL_POS_MAX = 64'h07FF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VOL_NEG_MAG = 64'h0800_0000_0000_0000;

    typedef struct packed {
        logic [TAG_W-1:0]             face_tag;
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } facet_t;

    typedef struct packed {
        logic [TAG_W-1:0]             tag_out;
        logic signed [COORD_BITS-1:0] mid_x;
        logic signed [COORD_BITS-1:0] mid_y;
        logic signed [COORD_BITS-1:0] mid_z;
        logic [AREA_W-1:0]            area;
        logic signed [NORM_W-1:0]     norm_x;
        logic signed [NORM_W-1:0]     norm_y;
        logic signed [NORM_W-1:0]     norm_z;
        logic signed [VOL_W-1:0]      volume_term;
        logic                         degenerate;
    } result_t;

    // side data carried alongside the square root
    typedef struct packed {
        logic [TAG_W-1:0]           tag;
        logic [2:0][COORD_BITS-1:0] mid;
        logic [VOL_W-1:0]           vol;
        logic [2:0][N_W-1:0]        nmag;
        logic [2:0]                 nsign;
    } side_a_t;

    // side data carried alongside the normal dividers
    typedef struct packed {
        logic [TAG_W-1:0]           tag;
        logic [2:0][COORD_BITS-1:0] mid;
        logic [VOL_W-1:0]           vol;
        logic [AREA_W-1:0]          area;
        logic                       degen;
        logic [2:0]                 nsign;
    } side_b_t;

    typedef struct packed {
        logic [1:0]         rem;
        logic [CHUNK_W-1:0] q;
    } d3_t;

    // one byte of long division by three, MSB first
    function automatic d3_t div3_byte(input logic [1:0] rin, input logic [CHUNK_W-1:0] d);
        d3_t        r;
        logic [2:0] t;
        r.rem = rin;
        r.q   = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            t = {r.rem, d[i]};
            if (t >= 3'd3)
            begin
                r.q[i] = 1'b1;
                t      = t - 3'd3;
            end
            r.rem = t[1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/tcan_isqrt.sv */
// Pipelined floor square root, one result bit per stage.
module tcan_isqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [tcan_pkg::S_W-1:0]     s,
    output logic [tcan_pkg::LEN_W-1:0]   len
);
    localparam int SW = tcan_pkg::S_W;
    localparam int LW = tcan_pkg::LEN_W;

    logic [LW-1:0] root_reg [LW];
    logic [SW-1:0] rem_reg  [LW];

    genvar j;
    generate
        for (j = 0; j < LW; j++)
        begin : g_stage
            localparam int B = LW - 1 - j;
            logic [LW-1:0] root_in;
            logic [SW-1:0] rem_in;
            logic [SW:0]   delta;
            logic          take;
            logic [LW-1:0] root_next;
            logic [SW-1:0] rem_next;

            if (j == 0)
            begin : g_first
                assign root_in = '0;
                assign rem_in  = s;
            end
            else
            begin : g_rest
                assign root_in = root_reg[j-1];
                assign rem_in  = rem_reg[j-1];
            end

            // (r + 2^B)^2 - r^2
            always_comb
            begin
                delta     = ((SW+1)'(root_in) << (B + 1)) + ((SW+1)'(1) << (2 * B));
                take      = {1'b0, rem_in} >= delta;
                root_next = take ? (root_in | (LW'(1) << B)) : root_in;
                rem_next  = take ? SW'({1'b0, rem_in} - delta) : rem_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[j] <= root_next;
                    rem_reg[j]  <= rem_next;
                end
            end
        end
    endgenerate

    assign len = root_reg[LW-1];

endmodule

/* hw/rtl/tcan_frac.sv */
// Pipelined fraction num * 2^30 / den, restoring division, one quotient bit per stage.
module tcan_frac (
    input  logic                          clk,
    input  logic                          en,
    input  logic [tcan_pkg::N_W-1:0]      num,
    input  logic [tcan_pkg::LEN_W-1:0]    den,
    output logic [tcan_pkg::FRAC_W-1:0]   quo
);
    localparam int LW = tcan_pkg::LEN_W;
    localparam int FW = tcan_pkg::FRAC_W;

    logic [LW-1:0] r_reg   [FW];
    logic [FW-1:0] q_reg   [FW];
    logic [LW-1:0] den_reg [FW];

    genvar j;
    generate
        for (j = 0; j < FW; j++)
        begin : g_stage
            logic [LW:0]   part;
            logic [LW-1:0] d_in;
            logic [FW-1:0] q_in;
            logic          ge;
            logic [LW-1:0] r_next;
            logic [FW-1:0] q_next;

            if (j == 0)
            begin : g_first
                assign part = (LW+1)'(num);
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign part = {r_reg[j-1], 1'b0};
                assign d_in = den_reg[j-1];
                assign q_in = q_reg[j-1];
            end

            always_comb
            begin
                ge     = part >= {1'b0, d_in};
                r_next = ge ? LW'(part - {1'b0, d_in}) : LW'(part);
                q_next = {q_in[FW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j]   <= r_next;
                    q_reg[j]   <= q_next;
                    den_reg[j] <= d_in;
                end
            end
        end
    endgenerate

    assign quo = q_reg[FW-1];

endmodule

/* hw/rtl/triangle_centroid_area_normal.sv */
// Top level: streaming triangle centroid, area, unit normal and volume term.
//
// One triangle request enters per clock and one result leaves per clock, in order. From
// acceptance to the result register the path runs, at the default coordinate width, through six
// stages of edge vectors, cross products and squared length, 50 stages of the square root
// (one result bit per stage), then 31 stages of the three normal dividers running side by
// side (one quotient bit per stage); centroid and volume divide by three a byte per stage in
// the shadow of the square root. The whole pipeline moves on one enable that is high while
// the two-entry result queue has room, so a request is taken while at most one finished
// result waits; when the queue is full (two results waiting), facet_ready drops and every
// stage holds, also in a cycle where one of the two is being read out.
module triangle_centroid_area_normal (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              facet_valid,
    output logic              facet_ready,
    input  tcan_pkg::facet_t  facet,
    output logic              result_valid,
    input  logic              result_ready,
    output tcan_pkg::result_t result
);
    localparam int CB     = tcan_pkg::COORD_BITS;
    localparam int CEND   = 2 + tcan_pkg::CCH;          // last centroid divide stage
    localparam int S_MID  = CEND + 1;                   // centroid lands in side line
    localparam int S_T    = 6;                          // squared length, triple product
    localparam int VEND   = S_T + 1 + tcan_pkg::VCH;    // last volume divide stage
    localparam int S_VOL  = VEND + 1;                   // volume lands in side line
    localparam int S_LEN  = S_T + tcan_pkg::LEN_W;      // square root out
    localparam int S_LAST = S_LEN + tcan_pkg::FRAC_W;   // normals out

    logic              en;
    logic [S_LAST:1]   v_reg;

    // result queue
    tcan_pkg::result_t fifo_reg [2];
    logic              wptr_reg;
    logic              rptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic              pop;
    tcan_pkg::result_t res_next;

    assign en          = (cnt_reg != 2'd2);
    assign facet_ready = en;
    assign push        = en && v_reg[S_LAST];
    assign pop         = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[S_LAST-1:1], facet_valid};
        end
    end

    // ---------------- stage 1: edges and coordinate sums
    logic signed [CB-1:0]             pa [3];
    logic signed [CB-1:0]             pb [3];
    logic signed [CB-1:0]             pc [3];
    logic [tcan_pkg::TAG_W-1:0]       tag1_reg;
    logic signed [CB-1:0]             a1_reg [3];
    logic signed [CB-1:0]             b1_reg [3];
    logic signed [CB-1:0]             c1_reg [3];
    logic signed [tcan_pkg::D_W-1:0]  e1_reg [3];
    logic signed [tcan_pkg::D_W-1:0]  f1_reg [3];
    logic signed [tcan_pkg::CS_W-1:0] sum1_reg [3];
    logic signed [tcan_pkg::D_W-1:0]  e1_next [3];
    logic signed [tcan_pkg::D_W-1:0]  f1_next [3];
    logic signed [tcan_pkg::CS_W-1:0] sum1_next [3];

    assign pa[0] = facet.a_x;
    assign pa[1] = facet.a_y;
    assign pa[2] = facet.a_z;
    assign pb[0] = facet.b_x;
    assign pb[1] = facet.b_y;
    assign pb[2] = facet.b_z;
    assign pc[0] = facet.c_x;
    assign pc[1] = facet.c_y;
    assign pc[2] = facet.c_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i]   = tcan_pkg::D_W'(pb[i]) - tcan_pkg::D_W'(pa[i]);
            f1_next[i]   = tcan_pkg::D_W'(pc[i]) - tcan_pkg::D_W'(pa[i]);
            sum1_next[i] = tcan_pkg::CS_W'(pa[i]) + tcan_pkg::CS_W'(pb[i])
                         + tcan_pkg::CS_W'(pc[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg <= facet.face_tag;
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i]   <= pa[i];
                b1_reg[i]   <= pb[i];
                c1_reg[i]   <= pc[i];
                e1_reg[i]   <= e1_next[i];
                f1_reg[i]   <= f1_next[i];
                sum1_reg[i] <= sum1_next[i];
            end
        end
    end

    // ---------------- stage 2: cross product terms, start of centroid divide
    logic [tcan_pkg::TAG_W-1:0]       tag2_reg;
    logic signed [CB-1:0]             a2_reg [3];
    logic signed [tcan_pkg::PN_W-1:0] pn2_reg [6];
    logic signed [tcan_pkg::PB_W-1:0] pbc2_reg [6];
    logic signed [tcan_pkg::PN_W-1:0] pn2_next [6];
    logic signed [tcan_pkg::PB_W-1:0] pbc2_next [6];

    logic [tcan_pkg::CW_W-1:0] cwork_reg [2:CEND][3];
    logic [1:0]                crem_reg  [2:CEND][3];
    logic                      cneg_reg  [2:CEND][3];
    logic [tcan_pkg::CS_W-1:0] cmag2_next [3];

    always_comb
    begin
        pn2_next[0]  = e1_reg[1] * f1_reg[2];
        pn2_next[1]  = e1_reg[2] * f1_reg[1];
        pn2_next[2]  = e1_reg[2] * f1_reg[0];
        pn2_next[3]  = e1_reg[0] * f1_reg[2];
        pn2_next[4]  = e1_reg[0] * f1_reg[1];
        pn2_next[5]  = e1_reg[1] * f1_reg[0];
        pbc2_next[0] = b1_reg[1] * c1_reg[2];
        pbc2_next[1] = b1_reg[2] * c1_reg[1];
        pbc2_next[2] = b1_reg[2] * c1_reg[0];
        pbc2_next[3] = b1_reg[0] * c1_reg[2];
        pbc2_next[4] = b1_reg[0] * c1_reg[1];
        pbc2_next[5] = b1_reg[1] * c1_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            cmag2_next[i] = sum1_reg[i][tcan_pkg::CS_W-1] ? tcan_pkg::CS_W'(-sum1_reg[i])
                                                           : tcan_pkg::CS_W'(sum1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag2_reg <= tag1_reg;
            for (int i = 0; i < 6; i++)
            begin
                pn2_reg[i]  <= pn2_next[i];
                pbc2_reg[i] <= pbc2_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i]       <= a1_reg[i];
                cwork_reg[2][i] <= tcan_pkg::CW_W'(cmag2_next[i]);
                crem_reg[2][i]  <= 2'd0;
                cneg_reg[2][i]  <= sum1_reg[i][tcan_pkg::CS_W-1];
            end
        end
    end

    // centroid magnitude / 3, one byte per stage; work word ends up as the quotient
    genvar k;
    generate
        for (k = 3; k <= CEND; k++)
        begin : g_cdiv
            tcan_pkg::d3_t step [3];
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    step[i] = tcan_pkg::div3_byte(crem_reg[k-1][i],
                        cwork_reg[k-1][i][tcan_pkg::CW_W-1 -: tcan_pkg::CHUNK_W]);
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        cwork_reg[k][i] <= {cwork_reg[k-1][i][tcan_pkg::CW_W-tcan_pkg::CHUNK_W-1:0],
                                            step[i].q};
                        crem_reg[k][i]  <= step[i].rem;
                        cneg_reg[k][i]  <= cneg_reg[k-1][i];
                    end
                end
            end
        end
    endgenerate

    // ---------------- side line: tag, normal magnitudes and signs, centroid, volume
    tcan_pkg::side_a_t side_reg  [3:S_LEN];
    tcan_pkg::side_a_t side_next [3:S_LEN];

    // ---------------- stage 3: normal vector and b x c
    logic signed [CB-1:0]             a3_reg [3];
    logic [tcan_pkg::BC_W-1:0]        bcm3_reg [3];
    logic                             bcs3_reg [3];
    logic [tcan_pkg::BC_W-1:0]        bcm3_next [3];
    logic                             bcs3_next [3];
    logic signed [tcan_pkg::PN_W:0]   nd [3];
    logic signed [tcan_pkg::PB_W:0]   bd [3];

    always_comb
    begin
        side_next[3]     = '0;
        side_next[3].tag = tag2_reg;
        for (int i = 0; i < 3; i++)
        begin
            nd[i] = (tcan_pkg::PN_W+1)'(pn2_reg[2*i]) - (tcan_pkg::PN_W+1)'(pn2_reg[2*i+1]);
            side_next[3].nsign[i] = nd[i][tcan_pkg::PN_W];
            side_next[3].nmag[i]  = nd[i][tcan_pkg::PN_W] ? tcan_pkg::N_W'(-nd[i])
                                                          : tcan_pkg::N_W'(nd[i]);
            bd[i] = (tcan_pkg::PB_W+1)'(pbc2_reg[2*i]) - (tcan_pkg::PB_W+1)'(pbc2_reg[2*i+1]);
            bcs3_next[i] = bd[i][tcan_pkg::PB_W];
            bcm3_next[i] = bd[i][tcan_pkg::PB_W] ? tcan_pkg::BC_W'(-bd[i])
                                                 : tcan_pkg::BC_W'(bd[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[3] <= side_next[3];
            for (int i = 0; i < 3; i++)
            begin
                a3_reg[i]   <= a2_reg[i];
                bcm3_reg[i] <= bcm3_next[i];
                bcs3_reg[i] <= bcs3_next[i];
            end
        end
    end

    // ---------------- stage 4: partial products of squares and of a.(b x c)
    logic [2*tcan_pkg::NH_W-1:0]           hh4_reg [3];
    logic [tcan_pkg::NH_W+tcan_pkg::NL_W-1:0] hl4_reg [3];
    logic [2*tcan_pkg::NL_W-1:0]           ll4_reg [3];
    logic [CB+tcan_pkg::BCH_W-1:0]         vph4_reg [3];
    logic [CB+tcan_pkg::BCL_W-1:0]         vpl4_reg [3];
    logic                                  vs4_reg [3];
    logic [tcan_pkg::NH_W-1:0]             nh [3];
    logic [tcan_pkg::NL_W-1:0]             nl [3];
    logic [CB-1:0]                         amag [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nh[i]   = side_reg[3].nmag[i][tcan_pkg::N_W-1:tcan_pkg::NL_W];
            nl[i]   = side_reg[3].nmag[i][tcan_pkg::NL_W-1:0];
            amag[i] = a3_reg[i][CB-1] ? CB'(-a3_reg[i]) : CB'(a3_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hh4_reg[i]  <= nh[i] * nh[i];
                hl4_reg[i]  <= nh[i] * nl[i];
                ll4_reg[i]  <= nl[i] * nl[i];
                vph4_reg[i] <= amag[i] * bcm3_reg[i][tcan_pkg::BC_W-1:tcan_pkg::BCL_W];
                vpl4_reg[i] <= amag[i] * bcm3_reg[i][tcan_pkg::BCL_W-1:0];
                vs4_reg[i]  <= a3_reg[i][CB-1] ^ bcs3_reg[i];
            end
        end
    end

    // ---------------- stage 5: squares and signed triple product terms
    logic [tcan_pkg::S_W-1:0]        sq5_reg [3];
    logic signed [tcan_pkg::T_W-1:0] vp5_reg [3];
    logic [tcan_pkg::S_W-1:0]        sq5_next [3];
    logic signed [tcan_pkg::T_W-1:0] vp5_next [3];
    logic [tcan_pkg::VP_W-1:0]       vprod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq5_next[i] = (tcan_pkg::S_W'(hh4_reg[i]) << (2 * tcan_pkg::NL_W))
                        + (tcan_pkg::S_W'(hl4_reg[i]) << (tcan_pkg::NL_W + 1))
                        + tcan_pkg::S_W'(ll4_reg[i]);
            vprod[i]    = (tcan_pkg::VP_W'(vph4_reg[i]) << tcan_pkg::BCL_W)
                        + tcan_pkg::VP_W'(vpl4_reg[i]);
            vp5_next[i] = vs4_reg[i] ? -$signed(tcan_pkg::T_W'(vprod[i]))
                                     : $signed(tcan_pkg::T_W'(vprod[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= sq5_next[i];
                vp5_reg[i] <= vp5_next[i];
            end
        end
    end

    // ---------------- stage 6: squared length and triple product
    logic [tcan_pkg::S_W-1:0]        s6_reg;
    logic signed [tcan_pkg::T_W-1:0] t6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_reg <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            t6_reg <= vp5_reg[0] + vp5_reg[1] + vp5_reg[2];
        end
    end

    // ---------------- volume: |T| >> 17, then / 3 a byte per stage
    logic [tcan_pkg::VW_W-1:0] vwork_reg [S_T+1:VEND];
    logic [1:0]                vrem_reg  [S_T+1:VEND];
    logic                      vneg_reg  [S_T+1:VEND];
    logic [tcan_pkg::T_W-1:0]  tmag;

    assign tmag = t6_reg[tcan_pkg::T_W-1] ? tcan_pkg::T_W'(-t6_reg) : tcan_pkg::T_W'(t6_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vwork_reg[S_T+1] <= tcan_pkg::VW_W'(tmag >> tcan_pkg::VOL_SHIFT);
            vrem_reg[S_T+1]  <= 2'd0;
            vneg_reg[S_T+1]  <= t6_reg[tcan_pkg::T_W-1];
        end
    end

    generate
        for (k = S_T + 2; k <= VEND; k++)
        begin : g_vdiv
            tcan_pkg::d3_t step;
            assign step = tcan_pkg::div3_byte(vrem_reg[k-1],
                vwork_reg[k-1][tcan_pkg::VW_W-1 -: tcan_pkg::CHUNK_W]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vwork_reg[k] <= {vwork_reg[k-1][tcan_pkg::VW_W-tcan_pkg::CHUNK_W-1:0], step.q};
                    vrem_reg[k]  <= step.rem;
                    vneg_reg[k]  <= vneg_reg[k-1];
                end
            end
        end
    endgenerate

    // volume with saturation to the 60-bit range
    logic [63:0]           vq;
    logic [63:0]           vlim;
    logic [tcan_pkg::VOL_W-1:0] vol_val;

    always_comb
    begin
        vq = 64'(vwork_reg[VEND]);
        if (vneg_reg[VEND])
        begin
            vlim = (vq > tcan_pkg::VOL_NEG_MAG) ? tcan_pkg::VOL_NEG_MAG : vq;
            vlim = 64'd0 - vlim;
        end
        else
        begin
            vlim = (vq > tcan_pkg::VOL_POS_MAX) ? tcan_pkg::VOL_POS_MAX : vq;
        end
        vol_val = vlim[tcan_pkg::VOL_W-1:0];
    end

    // side line shift, centroid and volume dropped in where they finish
    generate
        for (k = 4; k <= S_LEN; k++)
        begin : g_side
            always_comb
            begin
                side_next[k] = side_reg[k-1];
                if (k == S_MID)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        side_next[k].mid[i] = cneg_reg[CEND][i] ? CB'(-cwork_reg[CEND][i])
                                                                : CB'(cwork_reg[CEND][i]);
                    end
                end
                if (k == S_VOL)
                begin
                    side_next[k].vol = vol_val;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= side_next[k];
                end
            end
        end
    endgenerate

    // ---------------- square root
    logic [tcan_pkg::LEN_W-1:0] len;

    tcan_isqrt u_isqrt (
        .clk (clk),
        .en  (en),
        .s   (s6_reg),
        .len (len)
    );

    // ---------------- unit normal dividers, one per axis
    logic [tcan_pkg::FRAC_W-1:0] quo [3];

    generate
        for (k = 0; k < 3; k++)
        begin : g_frac
            tcan_frac u_frac (
                .clk (clk),
                .en  (en),
                .num (side_reg[S_LEN].nmag[k]),
                .den (len),
                .quo (quo[k])
            );
        end
    endgenerate

    // second side line: area and degenerate flag join here
    tcan_pkg::side_b_t sb_reg  [S_LEN+1:S_LAST];
    tcan_pkg::side_b_t sb_next;
    logic [tcan_pkg::LEN_W-2:0] half_len;

    always_comb
    begin
        half_len      = len[tcan_pkg::LEN_W-1:1];
        sb_next.tag   = side_reg[S_LEN].tag;
        sb_next.mid   = side_reg[S_LEN].mid;
        sb_next.vol   = side_reg[S_LEN].vol;
        sb_next.nsign = side_reg[S_LEN].nsign;
        sb_next.degen = (len == '0);
        sb_next.area  = (half_len > (tcan_pkg::LEN_W-1)'({tcan_pkg::AREA_W{1'b1}}))
                      ? {tcan_pkg::AREA_W{1'b1}} : tcan_pkg::AREA_W'(half_len);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[S_LEN+1] <= sb_next;
            for (int j = S_LEN + 2; j <= S_LAST; j++)
            begin
                sb_reg[j] <= sb_reg[j-1];
            end
        end
    end

    // ---------------- result assembly
    logic [tcan_pkg::NORM_W-1:0] nv [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (sb_reg[S_LAST].degen)
            begin
                nv[i] = '0;
            end
            else if (sb_reg[S_LAST].nsign[i])
            begin
                nv[i] = tcan_pkg::NORM_W'(0) - tcan_pkg::NORM_W'(quo[i]);
            end
            else
            begin
                nv[i] = tcan_pkg::NORM_W'(quo[i]);
            end
        end
        res_next.tag_out     = sb_reg[S_LAST].tag;
        res_next.mid_x       = sb_reg[S_LAST].mid[0];
        res_next.mid_y       = sb_reg[S_LAST].mid[1];
        res_next.mid_z       = sb_reg[S_LAST].mid[2];
        res_next.area        = sb_reg[S_LAST].area;
        res_next.norm_x      = nv[0];
        res_next.norm_y      = nv[1];
        res_next.norm_z      = nv[2];
        res_next.volume_term = sb_reg[S_LAST].vol;
        res_next.degenerate  = sb_reg[S_LAST].degen;
    end

    // ---------------- two-entry result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= res_next;
        end
    end

    assign result_valid = (cnt_reg != 2'd0);
    assign result       = fifo_reg[rptr_reg];

    // ---------------- assertions
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved during stall");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |->
            result.norm_x == 0 && result.norm_y == 0 && result.norm_z == 0 &&
            result.area == 0)
        else $error("degenerate result with nonzero normal or area");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.norm_x <= 32'sd1073741824 && result.norm_x >= -32'sd1073741824 &&
            result.norm_y <= 32'sd1073741824 && result.norm_y >= -32'sd1073741824 &&
            result.norm_z <= 32'sd1073741824 && result.norm_z >= -32'sd1073741824)
        else $error("unit normal component beyond one");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg != 2'd2)
        else $error("push into full result queue");

endmodule

/* bench/testbench.sv */
// Testbench for the triangle centroid, area, normal and volume pipeline.
`timescale 1ns / 1ps

class facet_scoreboard;
    tcan_pkg::result_t pending_q[$];
    int                errors;

    function new();
        errors = 0;
    endfunction

    // Expected result of one triangle; exact integer math at the block's widths.
    function tcan_pkg::result_t predict(tcan_pkg::facet_t f);
        longint              a[3], b[3], c[3], d1[3], d2[3], nv[3], bc[3];
        longint unsigned     len, probe, nm;
        logic [127:0]        sq, qt;
        logic signed [127:0] tp, wa, wb;
        logic [63:0]         v;
        bit                  neg;
        tcan_pkg::result_t   r;
        a[0] = $signed(f.a_x); a[1] = $signed(f.a_y); a[2] = $signed(f.a_z);
        b[0] = $signed(f.b_x); b[1] = $signed(f.b_y); b[2] = $signed(f.b_z);
        c[0] = $signed(f.c_x); c[1] = $signed(f.c_y); c[2] = $signed(f.c_z);
        for (int i = 0; i < 3; i++)
        begin
            d1[i] = b[i] - a[i];
            d2[i] = c[i] - a[i];
        end
        r.tag_out = f.face_tag;
        // division of signed longint truncates toward zero
        r.mid_x = tcan_pkg::COORD_BITS'((a[0] + b[0] + c[0]) / 3);
        r.mid_y = tcan_pkg::COORD_BITS'((a[1] + b[1] + c[1]) / 3);
        r.mid_z = tcan_pkg::COORD_BITS'((a[2] + b[2] + c[2]) / 3);

        // edge cross product and its squared length
        nv[0] = d1[1] * d2[2] - d1[2] * d2[1];
        nv[1] = d1[2] * d2[0] - d1[0] * d2[2];
        nv[2] = d1[0] * d2[1] - d1[1] * d2[0];
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            nm = (nv[i] < 0) ? -nv[i] : nv[i];
            sq = sq + 128'(nm) * 128'(nm);
        end
        // floor square root, one bit at a time
        len = 0;
        for (int k = 52; k >= 0; k--)
        begin
            probe = len | (64'd1 << k);
            if (128'(probe) * 128'(probe) <= sq)
                len = probe;
        end
        r.area = ((len >> 1) > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : len[48:1];

        // unit normal in Q1.30, zero when degenerate
        begin
            logic [31:0] nq[3];
            for (int i = 0; i < 3; i++)
            begin
                v = '0;
                if (len != 0)
                begin
                    nm = (nv[i] < 0) ? -nv[i] : nv[i];
                    qt = (128'(nm) << 30) / 128'(len);
                    v  = qt[63:0];
                    if (nv[i] < 0)
                        v = -v;
                end
                nq[i] = v[31:0];
            end
            r.norm_x = nq[0];
            r.norm_y = nq[1];
            r.norm_z = nq[2];
        end

        // triple product a.(b x c), scaled by 1/(6*2^16), saturated
        bc[0] = b[1] * c[2] - b[2] * c[1];
        bc[1] = b[2] * c[0] - b[0] * c[2];
        bc[2] = b[0] * c[1] - b[1] * c[0];
        tp = '0;
        for (int i = 0; i < 3; i++)
        begin
            wa = 128'(a[i]);
            wb = 128'(bc[i]);
            tp = tp + wa * wb;
        end
        neg = tp < 0;
        qt  = neg ? -tp : tp;
        qt  = qt / 128'd393216;
        if (neg)
        begin
            v = (qt > 128'(tcan_pkg::VOL_NEG_MAG)) ? tcan_pkg::VOL_NEG_MAG : qt[63:0];
            v = -v;
        end
        else
            v = (qt > 128'(tcan_pkg::VOL_POS_MAX)) ? tcan_pkg::VOL_POS_MAX : qt[63:0];
        r.volume_term = v[tcan_pkg::VOL_W-1:0];
        r.degenerate  = (len == 0);
        return r;
    endfunction

    function void note_request(tcan_pkg::facet_t f);
        pending_q.push_back(predict(f));
    endfunction

    function void field_cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
        end
    endfunction

    function void check_result(tcan_pkg::result_t got);
        tcan_pkg::result_t exp_r;
        if (pending_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            return;
        end
        exp_r = pending_q.pop_front();
        field_cmp("tag_out", 64'(exp_r.tag_out), 64'(got.tag_out));
        field_cmp("mid_x", 64'(exp_r.mid_x), 64'(got.mid_x));
        field_cmp("mid_y", 64'(exp_r.mid_y), 64'(got.mid_y));
        field_cmp("mid_z", 64'(exp_r.mid_z), 64'(got.mid_z));
        field_cmp("area", 64'(exp_r.area), 64'(got.area));
        field_cmp("norm_x", 64'(exp_r.norm_x), 64'(got.norm_x));
        field_cmp("norm_y", 64'(exp_r.norm_y), 64'(got.norm_y));
        field_cmp("norm_z", 64'(exp_r.norm_z), 64'(got.norm_z));
        field_cmp("volume_term", 64'(exp_r.volume_term), 64'(got.volume_term));
        field_cmp("degenerate", 64'(exp_r.degenerate), 64'(got.degenerate));
    endfunction
endclass

module testbench;
    localparam int   MAX_C    = (1 << (tcan_pkg::COORD_BITS - 1)) - 1;
    localparam int   MIN_C    = -(1 << (tcan_pkg::COORD_BITS - 1));
    localparam int   RAND_PER = 225;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              facet_valid = 1'b0;
    logic              facet_ready;
    tcan_pkg::facet_t  facet = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    tcan_pkg::result_t result;

    facet_scoreboard sb = new();

    // idle percentages per phase, and a receiver hold-off counted down in cycles
    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;

    always #4 clk = ~clk;

    triangle_centroid_area_normal uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .facet_valid  (facet_valid),
        .facet_ready  (facet_ready),
        .facet        (facet),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Present one request at a falling edge and hold it until the block takes it.
    // Returns right after a falling edge, so the next request or gap starts cleanly.
    task automatic send_facet(tcan_pkg::facet_t f);
        if ($urandom_range(99) < send_idle)
        begin
            facet_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        facet       = f;
        facet_valid = 1'b1;
        do
            @(posedge clk);
        while (!facet_ready);
        sb.note_request(f);
        @(negedge clk);
    endtask

    function automatic tcan_pkg::facet_t build(int tag, int ax, int ay, int az,
                                               int bx, int by, int bz,
                                               int cx, int cy, int cz);
        tcan_pkg::facet_t f;
        f.face_tag = tcan_pkg::TAG_W'(tag);
        f.a_x = tcan_pkg::COORD_BITS'(ax);
        f.a_y = tcan_pkg::COORD_BITS'(ay);
        f.a_z = tcan_pkg::COORD_BITS'(az);
        f.b_x = tcan_pkg::COORD_BITS'(bx);
        f.b_y = tcan_pkg::COORD_BITS'(by);
        f.b_z = tcan_pkg::COORD_BITS'(bz);
        f.c_x = tcan_pkg::COORD_BITS'(cx);
        f.c_y = tcan_pkg::COORD_BITS'(cy);
        f.c_z = tcan_pkg::COORD_BITS'(cz);
        return f;
    endfunction

    function automatic int pick_extreme();
        return $urandom_range(1) ? MAX_C : MIN_C;
    endfunction

    // Random triangle: full range, small local patch, corner extremes, or collinear.
    function automatic tcan_pkg::facet_t rand_facet();
        tcan_pkg::facet_t f;
        logic [255:0]     raw;
        int               ctr[3], d[3], e[3], k;
        f = '0;
        f.face_tag = tcan_pkg::TAG_W'($urandom);
        case ($urandom_range(9))
            0, 1, 2:
            begin
                raw = {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
                f   = raw[$bits(tcan_pkg::facet_t)-1:0];
            end
            3, 4, 5:
            begin
                // mesh-like patch: vertices close together
                for (int i = 0; i < 3; i++)
                begin
                    ctr[i] = int'($urandom_range(2 * MAX_C)) + MIN_C + 1;
                    d[i]   = int'($urandom_range(8191)) - 4096;
                    e[i]   = int'($urandom_range(8191)) - 4096;
                end
                f = build($urandom, ctr[0], ctr[1], ctr[2], ctr[0] + d[0], ctr[1] + d[1],
                          ctr[2] + d[2], ctr[0] + e[0], ctr[1] + e[1], ctr[2] + e[2]);
            end
            6, 7:
            begin
                f = build($urandom, pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), pick_extreme());
            end
            default:
            begin
                // collinear or coincident vertices: zero cross product
                k = int'($urandom_range(6)) - 3;
                for (int i = 0; i < 3; i++)
                begin
                    ctr[i] = int'($urandom_range(1 << 21)) - (1 << 20);
                    d[i]   = int'($urandom_range(4095)) - 2048;
                end
                f = build($urandom, ctr[0], ctr[1], ctr[2], ctr[0] + d[0], ctr[1] + d[1],
                          ctr[2] + d[2], ctr[0] + k * d[0], ctr[1] + k * d[1],
                          ctr[2] + k * d[2]);
            end
        endcase
        return f;
    endfunction

    // Receiver: ready changes at falling edges, results sampled at rising edges.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready = 1'b0;
                hold_left--;
            end
            else
                result_ready = ($urandom_range(99) >= recv_stall);
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int idle_tab[4];
        int stall_tab[4];
        int waited;
        idle_tab  = '{0, 46, 0, 34};
        stall_tab = '{0, 0, 46, 34};

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, zero area, saturation, tag ends
        send_facet(build(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_facet(build((1 << tcan_pkg::TAG_W) - 1, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C,
                         MAX_C, MAX_C, MAX_C, MAX_C));
        send_facet(build(1, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C));
        send_facet(build(2, 0, 0, 0, 65536, 0, 0, 0, 65536, 0));
        send_facet(build(3, 0, 0, 0, 0, 65536, 0, 65536, 0, 0));
        send_facet(build(4, 0, 0, 0, 0, 0, 65536, 0, 65536, 0));
        send_facet(build(5, MIN_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_C, MIN_C));
        send_facet(build(6, MIN_C, MAX_C, 0, MAX_C, MIN_C, 0, MAX_C, MAX_C, MAX_C));
        send_facet(build(7, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C));
        send_facet(build(8, MAX_C, MIN_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_C));
        send_facet(build(9, MIN_C, 0, MAX_C, 0, MAX_C, MIN_C, MAX_C, MIN_C, 0));
        send_facet(build(10, 100, 200, 300, 200, 400, 600, 300, 600, 900));
        send_facet(build(11, -5, 7, -1, -5, 7, -1, 12, 3, 9));
        send_facet(build(12, 1, 1, 1, 2, 1, 1, 1, 2, 1));
        send_facet(build(13, -1, -1, -1, -1, -1, -1, -1, -1, -2));
        send_facet(build(14, -1, 0, 0, -1, 0, 0, 0, 0, 0));
        send_facet(build(15, MAX_C, 0, MIN_C, MIN_C, MAX_C, 0, 0, MIN_C, MAX_C));
        send_facet(build(16, 0, 0, 0, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C));
        send_facet(build(17, 1, 0, 0, 0, 1, 0, 0, 0, 1));

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle  = idle_tab[ph];
            recv_stall = stall_tab[ph];
            // long receiver hold-off while requests keep coming: pipeline backs up
            if (ph == 2)
                hold_left = 400;
            for (int n = 0; n < RAND_PER; n++)
                send_facet(rand_facet());
        end
        facet_valid = 1'b0;

        waited = 0;
        while (sb.pending_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (120) @(posedge clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
